// ----- rtl/core/elrs_pkg.sv -----
// Shared types and constants for the event log ring store.
package elrs_pkg;

  localparam int RECORDS_DEF = 128;

  localparam logic [15:0] ID_FIRST = 16'h0000;
  localparam logic [15:0] ID_LAST  = 16'hFFFF;
  localparam logic [15:0] RSV_MIN  = 16'h0001;
  localparam logic [15:0] RSV_MAX  = 16'hFFFE;

  typedef enum logic [2:0] {
    OP_ADD          = 3'd0,
    OP_GET          = 3'd1,
    OP_RESERVE      = 3'd2,
    OP_ERASE        = 3'd3,
    OP_ERASE_STATUS = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STS_OK           = 2'd0,
    STS_EMPTY        = 2'd1,
    STS_BAD_ID       = 2'd2,
    STS_RSV_MISMATCH = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_LOAD
  } state_t;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } rec_t;

endpackage

// ----- rtl/core/elrs_store.sv -----
// Record store: one write port, one registered read port.
module elrs_store #(
  parameter int DEPTH = elrs_pkg::RECORDS_DEF + 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  elrs_pkg::rec_t           wr_rec,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output elrs_pkg::rec_t           rd_rec
);
  import elrs_pkg::*;

  rec_t mem [DEPTH];
  rec_t rd_rec_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rec_r <= mem[rd_addr];
    end
  end

  assign rd_rec = rd_rec_r;

endmodule

// ----- rtl/core/event_log_ring_store_top.sv -----
// Event log ring store: circular store of 16-byte records with reservation control.
//
//  channel | handshake            | beat contents
//  --------+----------------------+---------------------------------------------
//  in_     | in_valid / in_ready  | op, record_low/high, record_id, reservation,
//          |                      | time_now
//  out_    | out_valid/out_ready  | status, ids, record data, count, free bytes,
//          |                      | reservation, stamps
//
// Each beat has an execute cycle that updates the indices and issues the
// store access, then a load cycle that takes the registered read data into
// the output register. The next input beat is taken in the load cycle, so a
// new beat is accepted while the last result loads, as long as out_ready
// stays high. A held result stalls the load cycle only. Reset clears indices,
// count and stamps and sets the reservation to RSV_MIN; the store itself is left as it is.
module event_log_ring_store_top #(
  parameter int RECORDS = elrs_pkg::RECORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [63:0] in_record_low,
  input  logic [63:0] in_record_high,
  input  logic [15:0] in_record_id,
  input  logic [15:0] in_reservation,
  input  logic [31:0] in_time_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_added_id,
  output logic [15:0] out_next_id,
  output logic [63:0] out_data_low,
  output logic [63:0] out_data_high,
  output logic [7:0]  out_entry_count,
  output logic [11:0] out_free_bytes,
  output logic [15:0] out_reservation_out,
  output logic [31:0] out_last_add_time,
  output logic [31:0] out_last_erase_time
);
  import elrs_pkg::*;

  localparam int SLOTS = RECORDS + 1;
  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RECORDS);
  localparam logic [15:0]      LAST_SLOT16 = 16'(RECORDS);

  // control
  state_t state_r, state_nxt;
  logic   exec_en, load_en;

  // captured request
  logic [2:0]  op_r;
  logic [63:0] rec_low_r, rec_high_r;
  logic [15:0] rec_id_r, rsv_in_r;
  logic [31:0] now_r;

  // log state
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      rsv_r, rsv_nxt;
  logic [31:0]      add_stamp_r, add_stamp_nxt;
  logic [31:0]      erase_stamp_r, erase_stamp_nxt;

  // pending response from the execute cycle
  logic [1:0]  sts_r, sts_nxt;
  logic [7:0]  added_r, added_nxt;
  logic [15:0] next_id_r, next_id_nxt;
  logic        data_sel_r, data_sel_nxt;

  // output register
  logic        out_valid_r;
  logic [1:0]  o_status_r;
  logic [7:0]  o_added_r;
  logic [15:0] o_next_r;
  logic [63:0] o_dlo_r, o_dhi_r;
  logic [7:0]  o_cnt_r;
  logic [11:0] o_free_r;
  logic [15:0] o_rsv_r;
  logic [31:0] o_add_t_r, o_erase_t_r;

  // store access
  logic             wr_en, rd_en;
  rec_t             wr_rec, rd_rec;
  logic [15:0]      idx16;
  logic [IDX_W-1:0] idx, idx_wrap, tail_prev, tail_wrap, head_wrap;
  logic             in_range, get_ok;

  // index count recomputed from the pointers, for checking only
  logic [IDX_W:0]   ptr_diff;
  logic [IDX_W-1:0] ptr_held;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: if (in_valid) state_nxt = FSM_EXEC;
      FSM_EXEC: state_nxt = FSM_LOAD;
      FSM_LOAD: begin
        if (load_en) state_nxt = in_valid ? FSM_EXEC : FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    exec_en  = 1'b0;
    load_en  = 1'b0;
    in_ready = 1'b0;
    case (state_r)
      FSM_IDLE: in_ready = 1'b1;
      FSM_EXEC: exec_en = 1'b1;
      FSM_LOAD: begin
        load_en  = !out_valid_r || out_ready;
        in_ready = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r       <= in_op;
      rec_low_r  <= in_record_low;
      rec_high_r <= in_record_high;
      rec_id_r   <= in_record_id;
      rsv_in_r   <= in_reservation;
      now_r      <= in_time_now;
    end
  end

  // ------------------------------------------------------------ execute
  assign tail_prev = (tail_r == '0) ? LAST_SLOT : tail_r - IDX_W'(1);
  assign tail_wrap = (tail_r == LAST_SLOT) ? '0 : tail_r + IDX_W'(1);
  assign head_wrap = (head_r == LAST_SLOT) ? '0 : head_r + IDX_W'(1);

  always_comb begin
    if (rec_id_r == ID_FIRST) begin
      idx16 = 16'(head_r);
    end else if (rec_id_r == ID_LAST) begin
      idx16 = 16'(tail_prev);
    end else begin
      idx16 = rec_id_r - 16'd1;
    end
  end

  assign idx      = idx16[IDX_W-1:0];
  assign idx_wrap = (idx == LAST_SLOT) ? '0 : idx + IDX_W'(1);

  // occupied slots run from head up to, not including, tail
  always_comb begin
    if (idx16 > LAST_SLOT16) begin
      in_range = 1'b0;
    end else if (head_r < tail_r) begin
      in_range = (idx >= head_r) && (idx < tail_r);
    end else if (head_r > tail_r) begin
      in_range = (idx < tail_r) || (idx >= head_r);
    end else begin
      in_range = 1'b0;
    end
  end

  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    cnt_nxt         = cnt_r;
    rsv_nxt         = rsv_r;
    add_stamp_nxt   = add_stamp_r;
    erase_stamp_nxt = erase_stamp_r;
    sts_nxt         = STS_OK;
    added_nxt       = 8'd0;
    next_id_nxt     = 16'd0;
    data_sel_nxt    = 1'b0;
    get_ok          = 1'b0;
    wr_en           = 1'b0;
    wr_rec          = '{high: rec_high_r,
                        low: {rec_low_r[63:56], now_r, rec_low_r[23:0]}};
    case (op_t'(op_r))
      OP_ADD: begin
        wr_en = exec_en;
        // drop the oldest record when full
        if (cnt_r == LAST_SLOT) begin
          head_nxt = head_wrap;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
        added_nxt     = 8'(tail_r) + 8'd1;
        tail_nxt      = tail_wrap;
        add_stamp_nxt = now_r;
      end
      OP_GET: begin
        if (cnt_r == '0) begin
          sts_nxt = STS_EMPTY;
        end else if (!in_range) begin
          sts_nxt = STS_BAD_ID;
        end else begin
          get_ok       = 1'b1;
          data_sel_nxt = 1'b1;
          next_id_nxt  = (idx_wrap == tail_r) ? ID_LAST : 16'(idx_wrap) + 16'd1;
        end
      end
      OP_RESERVE: begin
        rsv_nxt = (rsv_r >= RSV_MAX) ? RSV_MIN : rsv_r + 16'd1;
      end
      OP_ERASE: begin
        if (rsv_in_r != rsv_r) begin
          sts_nxt = STS_RSV_MISMATCH;
        end else begin
          head_nxt        = '0;
          tail_nxt        = '0;
          cnt_nxt         = '0;
          erase_stamp_nxt = now_r;
        end
      end
      OP_ERASE_STATUS: begin
        if (rsv_in_r != rsv_r) sts_nxt = STS_RSV_MISMATCH;
      end
      default: ;
    endcase
  end

  assign rd_en = exec_en && get_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= '0;
      cnt_r         <= '0;
      rsv_r         <= RSV_MIN;
      add_stamp_r   <= '0;
      erase_stamp_r <= '0;
    end else if (exec_en) begin
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      cnt_r         <= cnt_nxt;
      rsv_r         <= rsv_nxt;
      add_stamp_r   <= add_stamp_nxt;
      erase_stamp_r <= erase_stamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      sts_r      <= sts_nxt;
      added_r    <= added_nxt;
      next_id_r  <= next_id_nxt;
      data_sel_r <= data_sel_nxt;
    end
  end

  elrs_store #(
    .DEPTH (SLOTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_rec  (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_rec  (rd_rec)
  );

  // --------------------------------------------------------------- load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      o_status_r  <= sts_r;
      o_added_r   <= added_r;
      o_next_r    <= next_id_r;
      o_dlo_r     <= data_sel_r ? rd_rec.low : 64'd0;
      o_dhi_r     <= data_sel_r ? rd_rec.high : 64'd0;
      o_cnt_r     <= 8'(cnt_r);
      o_free_r    <= {8'(RECORDS) - 8'(cnt_r), 4'b0000};
      o_rsv_r     <= rsv_r;
      o_add_t_r   <= add_stamp_r;
      o_erase_t_r <= erase_stamp_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_added_id        = o_added_r;
  assign out_next_id         = o_next_r;
  assign out_data_low        = o_dlo_r;
  assign out_data_high       = o_dhi_r;
  assign out_entry_count     = o_cnt_r;
  assign out_free_bytes      = o_free_r;
  assign out_reservation_out = o_rsv_r;
  assign out_last_add_time   = o_add_t_r;
  assign out_last_erase_time = o_erase_t_r;

  // ---------------------------------------------------------- assertions
  assign ptr_diff = {1'b0, tail_r} - {1'b0, head_r};
  assign ptr_held = ptr_diff[IDX_W] ? ptr_diff[IDX_W-1:0] + IDX_W'(SLOTS)
                                    : ptr_diff[IDX_W-1:0];

  a_count_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == ptr_held)
    else $error("record count disagrees with ring indices");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_SLOT)
    else $error("record count above capacity");

  a_rsv_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rsv_r != 16'h0000 && rsv_r != ID_LAST)
    else $error("reservation counter out of range");

  a_add_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_en && op_r == OP_ADD) |=> cnt_r != '0)
    else $error("log empty after add");

  a_exec_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    exec_en |=> state_r == FSM_LOAD && !exec_en)
    else $error("execute cycle not followed by load cycle");

endmodule

// ----- verif/tb_event_log_ring_store_top.sv -----
// Self-checking testbench for the event log ring store: directed, sweep and random beats.
module tb_event_log_ring_store_top;
  timeunit 1ns;
  timeprecision 1ps;
  import elrs_pkg::*;

  localparam int RECORDS         = RECORDS_DEF;
  localparam int SLOTS           = RECORDS + 1;
  localparam int RANDOM_BEATS    = 600;
  localparam int SEGMENTS        = 8;
  localparam int IDLE_PCT        = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 20;
  localparam logic [2:0] OP_UNUSED_MIN = 3'd5;
  localparam logic [2:0] OP_UNUSED_MAX = 3'd7;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  added;
    logic [15:0] next;
    logic [63:0] data_lo;
    logic [63:0] data_hi;
    logic [7:0]  count;
    logic [11:0] free;
    logic [15:0] rsv;
    logic [31:0] add_t;
    logic [31:0] erase_t;
  } log_reply_t;

  class ring_log_scoreboard;
    logic [63:0] slot_lo[SLOTS];
    logic [63:0] slot_hi[SLOTS];
    int          oldest;
    int          next_free;
    logic [15:0] rsv_id;
    logic [31:0] add_stamp;
    logic [31:0] erase_stamp;
    log_reply_t  replies_due[$];
    int mismatches, strays, beats, replies;
    int op_seen[8];
    int status_seen[4];
    int drops, rsv_wraps, wrapped_last_reads, peak;

    function new();
      foreach (slot_lo[i]) begin
        slot_lo[i] = '0;
        slot_hi[i] = '0;
      end
      oldest      = 0;
      next_free   = 0;
      rsv_id      = RSV_MIN;
      add_stamp   = '0;
      erase_stamp = '0;
    endfunction

    function int next_slot(int i);
      return (i + 1 > RECORDS) ? 0 : i + 1;
    endfunction

    function int held();
      return (oldest <= next_free) ? next_free - oldest : next_free + SLOTS - oldest;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // Work out the reply to one accepted request and queue it.
    function void note_request(logic [2:0] op, logic [63:0] rlo, logic [63:0] rhi,
                               logic [15:0] rid, logic [15:0] rsv, logic [31:0] now);
      log_reply_t r;
      int idx;
      int n;
      r = '{default: '0};
      beats++;
      op_seen[op]++;
      case (op)
        OP_ADD: begin
          if (held() == RECORDS) begin
            oldest = next_slot(oldest);
            drops++;
          end
          slot_lo[next_free] = {rlo[63:56], now, rlo[23:0]};
          slot_hi[next_free] = rhi;
          r.added = 8'(next_free + 1);
          next_free = next_slot(next_free);
          add_stamp = now;
        end
        OP_GET: begin
          if (rid == ID_FIRST) begin
            idx = oldest;
          end else if (rid == ID_LAST) begin
            idx = (next_free != 0) ? next_free - 1 : RECORDS;
            if (next_free == 0 && held() != 0) wrapped_last_reads++;
          end else begin
            idx = int'(rid) - 1;
          end
          if (held() == 0) begin
            r.status = STS_EMPTY;
          end else if (idx > RECORDS) begin
            r.status = STS_BAD_ID;
          end else if (oldest < next_free && (idx < oldest || idx >= next_free)) begin
            r.status = STS_BAD_ID;
          end else if (oldest > next_free && idx >= next_free && idx < oldest) begin
            r.status = STS_BAD_ID;
          end else begin
            n = next_slot(idx);
            r.data_lo = slot_lo[idx];
            r.data_hi = slot_hi[idx];
            r.next = (n == next_free) ? ID_LAST : 16'(n + 1);
          end
        end
        OP_RESERVE: begin
          if (rsv_id >= RSV_MAX) begin
            rsv_id = RSV_MIN;
            rsv_wraps++;
          end else begin
            rsv_id = rsv_id + 16'd1;
          end
        end
        OP_ERASE: begin
          if (rsv != rsv_id) begin
            r.status = STS_RSV_MISMATCH;
          end else begin
            oldest      = 0;
            next_free   = 0;
            erase_stamp = now;
          end
        end
        OP_ERASE_STATUS: begin
          if (rsv != rsv_id) r.status = STS_RSV_MISMATCH;
        end
        default: ;
      endcase
      r.count   = 8'(held());
      r.free    = 12'((RECORDS - held()) * 16);
      r.rsv     = rsv_id;
      r.add_t   = add_stamp;
      r.erase_t = erase_stamp;
      if (held() > peak) peak = held();
      status_seen[r.status]++;
      replies_due.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches + strays <= 10)
          $display("[%0t] result %0d %s: expected %h, got %h", $realtime, replies, field,
                   want, got);
      end
    endfunction

    function void check_reply(log_reply_t got);
      log_reply_t want;
      replies++;
      if (replies_due.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10)
          $display("[%0t] result %0d arrived with nothing outstanding", $realtime, replies);
        return;
      end
      want = replies_due.pop_front();
      compare("status", want.status, got.status);
      compare("added_id", want.added, got.added);
      compare("next_id", want.next, got.next);
      compare("data_low", want.data_lo, got.data_lo);
      compare("data_high", want.data_hi, got.data_hi);
      compare("entry_count", want.count, got.count);
      compare("free_bytes", want.free, got.free);
      compare("reservation_out", want.rsv, got.rsv);
      compare("last_add_time", want.add_t, got.add_t);
      compare("last_erase_time", want.erase_t, got.erase_t);
    endfunction

    function int failures();
      return mismatches + strays;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [63:0] in_record_low;
  logic [63:0] in_record_high;
  logic [15:0] in_record_id;
  logic [15:0] in_reservation;
  logic [31:0] in_time_now;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_added_id;
  logic [15:0] out_next_id;
  logic [63:0] out_data_low;
  logic [63:0] out_data_high;
  logic [7:0]  out_entry_count;
  logic [11:0] out_free_bytes;
  logic [15:0] out_reservation_out;
  logic [31:0] out_last_add_time;
  logic [31:0] out_last_erase_time;

  logic quiet;
  int   hold_requests;
  int   holds_done;

  ring_log_scoreboard book = new();

  event_log_ring_store_top #(.RECORDS(RECORDS)) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_record_low       (in_record_low),
    .in_record_high      (in_record_high),
    .in_record_id        (in_record_id),
    .in_reservation      (in_reservation),
    .in_time_now         (in_time_now),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_added_id        (out_added_id),
    .out_next_id         (out_next_id),
    .out_data_low        (out_data_low),
    .out_data_high       (out_data_high),
    .out_entry_count     (out_entry_count),
    .out_free_bytes      (out_free_bytes),
    .out_reservation_out (out_reservation_out),
    .out_last_add_time   (out_last_add_time),
    .out_last_erase_time (out_last_erase_time)
  );

  always #2 clk = ~clk;

  // Note the request beat before checking the result beat of the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        book.note_request(in_op, in_record_low, in_record_high, in_record_id,
                          in_reservation, in_time_now);
      if (out_valid && out_ready)
        book.check_reply(log_reply_t'{out_status, out_added_id, out_next_id, out_data_low,
                                      out_data_high, out_entry_count, out_free_bytes,
                                      out_reservation_out, out_last_add_time,
                                      out_last_erase_time});
    end
  end

  // Result side: random back-pressure, or a long hold-off when asked for.
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_requests != holds_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
      @(negedge clk);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Id of a slot that currently holds a record; first when the log is empty.
  function automatic logic [15:0] held_id();
    int k;
    if (book.held() == 0) return ID_FIRST;
    k = $urandom_range(book.held() - 1);
    return 16'((book.oldest + k) % SLOTS + 1);
  endfunction

  // Id of a slot that holds nothing; the write slot is always one of them.
  function automatic logic [15:0] empty_slot_id();
    int k;
    k = $urandom_range(SLOTS - book.held() - 1);
    return 16'((book.next_free + k) % SLOTS + 1);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer(input logic [2:0] op, input logic [63:0] rlo, input logic [63:0] rhi,
                       input logic [15:0] rid, input logic [15:0] rsv,
                       input logic [31:0] now);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_record_low  <= rlo;
    in_record_high <= rhi;
    in_record_id   <= rid;
    in_reservation <= rsv;
    in_time_now    <= now;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [15:0] rsv);
    offer(op, rand64(), rand64(), 16'($urandom), rsv, $urandom);
  endtask

  task automatic add_random();
    offer(OP_ADD, rand64(), rand64(), 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic get_id(input logic [15:0] id);
    offer(OP_GET, rand64(), rand64(), id, 16'($urandom), $urandom);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (book.pending() != 0);
  endtask

  task automatic random_beat(input bit erase_ok);
    int pick;
    pick = $urandom_range(999);
    if (pick < 440) begin
      add_random();
    end else if (pick < 720) begin
      case ($urandom_range(5))
        0:       get_id(ID_FIRST);
        1:       get_id(ID_LAST);
        2, 3:    get_id(held_id());
        4:       get_id(empty_slot_id());
        default: get_id(16'($urandom));
      endcase
    end else if (pick < 790) begin
      send_op(OP_RESERVE, 16'($urandom));
    end else if (pick < 810) begin
      send_op(OP_ERASE, erase_ok ? book.rsv_id : book.rsv_id + 16'd1);
    end else if (pick < 860) begin
      send_op(OP_ERASE, 16'($urandom));
    end else if (pick < 920) begin
      send_op(OP_ERASE_STATUS, $urandom_range(1) ? book.rsv_id : 16'($urandom));
    end else if (pick < 960) begin
      send_op(3'($urandom_range(OP_UNUSED_MAX, OP_UNUSED_MIN)), 16'($urandom));
    end else begin
      add_random();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_ADD;
    in_record_low  = '0;
    in_record_high = '0;
    in_record_id   = '0;
    in_reservation = '0;
    in_time_now    = '0;
    quiet          = 1'b0;
    hold_requests  = 0;
    holds_done     = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty log, reservation checks, field extremes and every id case.
    get_id(ID_FIRST);
    get_id(ID_LAST);
    send_op(OP_ERASE_STATUS, RSV_MIN);
    send_op(OP_ERASE_STATUS, 16'hFFFF);
    offer(OP_ADD, '0, '0, '0, '0, '1);
    offer(OP_ADD, '1, '1, '1, '1, '0);
    add_random();
    get_id(ID_FIRST);
    get_id(ID_LAST);
    get_id(16'd2);
    get_id(16'd4);
    get_id(16'(SLOTS));
    get_id(16'(SLOTS + 1));
    get_id(16'h8000);
    send_op(OP_RESERVE, '0);
    send_op(OP_ERASE, RSV_MIN);
    send_op(OP_ERASE_STATUS, book.rsv_id);
    send_op(OP_ERASE, book.rsv_id);
    get_id(ID_LAST);
    for (int op = OP_UNUSED_MIN; op <= OP_UNUSED_MAX; op++)
      send_op(3'(op), 16'($urandom));

    // No idling here: overfill so the write slot wraps, then probe the reservation checks.
    quiet = 1'b1;
    repeat (SLOTS) add_random();
    get_id(ID_LAST);
    get_id(ID_FIRST);
    get_id(16'd1);
    get_id(held_id());
    add_random();
    get_id(ID_LAST);
    send_op(OP_ERASE_STATUS, RSV_MAX);
    send_op(OP_ERASE, RSV_MIN);
    send_op(OP_RESERVE, 16'($urandom));
    send_op(OP_ERASE_STATUS, RSV_MIN);
    settle();
    quiet = 1'b0;

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 3) hold_requests++;
      if (seg == 5) settle();
      for (int i = 0; i < RANDOM_BEATS / SEGMENTS; i++) random_beat(seg % 2 == 1);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d beats (%0d add, %0d get, %0d reserve, %0d erase, ", book.beats,
             book.op_seen[OP_ADD], book.op_seen[OP_GET], book.op_seen[OP_RESERVE],
             book.op_seen[OP_ERASE], "%0d erase status, %0d unused op), %0d results checked.",
             book.op_seen[OP_ERASE_STATUS],
             book.op_seen[5] + book.op_seen[6] + book.op_seen[7], book.replies);
    $display("Outcomes %0d ok, %0d empty, %0d bad id, %0d mismatch; %0d oldest dropped, ",
             book.status_seen[STS_OK], book.status_seen[STS_EMPTY],
             book.status_seen[STS_BAD_ID], book.status_seen[STS_RSV_MISMATCH], book.drops,
             "%0d reservation wraps, %0d newest reads across the wrap, peak %0d held.",
             book.rsv_wraps, book.wrapped_last_reads, book.peak);
    if (book.failures() == 0 && book.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d stray results, %0d results missing", book.mismatches,
               book.strays, book.pending());
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", book.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule
